/* rtl/sensor_matrix_scan_debounce_assert.svh */
// Assertion macros for the sensor matrix scanner.
// Included by the top module for its concurrent checks; no other dependencies.
`ifndef SENSOR_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH
`define SENSOR_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH

// same-cycle implication
`define SMSD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/smsd_pkg.sv */
// Shared constants and types for the sensor matrix scanner with debounce.
// No dependencies; used by smsd_classify and sensor_matrix_scan_debounce.
package smsd_pkg;

   localparam int CHANNELS    = 16;
   localparam int BOARD_MUXES = 4;
   localparam int BLACK_LINE  = 0;
   localparam int BOARD_LINE0 = 1;
   localparam int WHITE_LINE  = 5;

   localparam logic [3:0] LAST_CHANNEL = 4'(CHANNELS - 1);
   localparam logic [3:0] COUNT_MAX    = 4'd15;
   localparam logic [3:0] STABLE_RESET = 4'd3;

   // register indexes on the csr port
   localparam logic [2:0] CSR_STABLE_SCANS = 3'd0;
   localparam logic [2:0] CSR_BASE_BOARD   = 3'd1;
   localparam logic [2:0] CSR_BASE_BLACK   = 3'd2;
   localparam logic [2:0] CSR_BASE_WHITE   = 3'd3;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_BLACK = 2'd1,
      KIND_WHITE = 2'd2,
      KIND_MULTI = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] slot;
   } capture_type;

endpackage

/* rtl/smsd_classify.sv */
// Classifies newly filled storage slots of a settled scan against the baseline.
// Depends on smsd_pkg (kind_type, capture_type).
module smsd_classify (
   input  logic [15:0]          black_slots,
   input  logic [15:0]          white_slots,
   input  logic [15:0]          base_black,
   input  logic [15:0]          base_white,
   output smsd_pkg::capture_type capture
);

   function automatic logic [3:0] lowest_one16(input logic [15:0] v);
      logic [3:0] pos;
      pos = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (v[i]) begin
            pos = 4'(i);
         end
      end
      return pos;
   endfunction

   logic [15:0] new_black;
   logic [15:0] new_white;
   logic        nb_zero, nb_one, nw_zero, nw_one;

   assign new_black = black_slots & ~base_black;
   assign new_white = white_slots & ~base_white;

   // exactly one bit set: nonzero and clearing the lowest bit leaves nothing
   assign nb_zero = (new_black == 16'd0);
   assign nw_zero = (new_white == 16'd0);
   assign nb_one  = !nb_zero && ((new_black & (new_black - 16'd1)) == 16'd0);
   assign nw_one  = !nw_zero && ((new_white & (new_white - 16'd1)) == 16'd0);

   always_comb begin
      capture.kind = smsd_pkg::KIND_MULTI;
      capture.slot = 4'd0;
      if (nb_zero && nw_zero) begin
         capture.kind = smsd_pkg::KIND_NONE;
      end else if (nb_one && nw_zero) begin
         capture.kind = smsd_pkg::KIND_BLACK;
         capture.slot = lowest_one16(new_black);
      end else if (nw_one && nb_zero) begin
         capture.kind = smsd_pkg::KIND_WHITE;
         capture.slot = lowest_one16(new_white);
      end
   end

endmodule

/* rtl/sensor_matrix_scan_debounce.sv */
// Top level of the multiplexed sensor matrix scanner with debounce.
// Depends on smsd_pkg, smsd_classify and sensor_matrix_scan_debounce_assert.svh.
//
// Usage:
//   req_ channel: one transaction per mux channel sample (channel number and six
//   active-low sense lines). Samples land in a partial scan; a sample on the last
//   channel closes the scan and runs the debounce step.
//   rsp_ channel: one transaction each time a debounced scan settles and differs
//   from the baseline: board, storage words, capture kind and slot.
//   csr_ port: write-only; index 0 stable_scans, 1 base_board, 2 base_black,
//   3 base_white; other indexes are ignored. Write only while idle.
// Timing: a sample is held in the input register; the scan update and settle
//   check run between that register and the result register that drives
//   rsp_valid, set as the sample leaves. One sample per cycle is taken while
//   req_stall is low; the single input register is the only buffering.
// Stall: while a result waits under rsp_stall, samples of channels other than the
//   last keep flowing; a last-channel sample waits in the input register and
//   req_stall rises until the pending result is taken.
// Reset: clears the partial scan, debounce candidate and count, restores the
//   registers to stable_scans 3 and zero baselines, and empties both stages.
`include "sensor_matrix_scan_debounce_assert.svh"

module sensor_matrix_scan_debounce (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_channel,
   input  logic [5:0]  req_sense_lines,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_board,
   output logic [15:0] rsp_black_slots,
   output logic [15:0] rsp_white_slots,
   output logic [1:0]  rsp_capture_kind,
   output logic [3:0]  rsp_capture_slot,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // configuration
   logic [3:0]  stable_scans_ff;
   logic [63:0] base_board_ff;
   logic [15:0] base_black_ff;
   logic [15:0] base_white_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [3:0]  s1_channel_ff;
   logic [5:0]  s1_lines_ff;

   // scan and debounce state
   logic [63:0] partial_board_ff, partial_board_in;
   logic [15:0] partial_black_ff, partial_black_in;
   logic [15:0] partial_white_ff, partial_white_in;
   logic [63:0] cand_board_ff, cand_board_in;
   logic [15:0] cand_black_ff, cand_black_in;
   logic [15:0] cand_white_ff, cand_white_in;
   logic [3:0]  stable_count_ff, stable_count_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_board_ff;
   logic [15:0] rsp_black_ff;
   logic [15:0] rsp_white_ff;
   smsd_pkg::capture_type rsp_capture_ff;

   logic        s1_last, s1_blocked, s1_fire, rsp_free;
   logic        scan_match, debounce_step, at_base, settle;
   logic [3:0]  threshold;
   smsd_pkg::capture_type capture;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_last    = (s1_channel_ff == smsd_pkg::LAST_CHANNEL);
   assign s1_blocked = s1_last && !rsp_free;
   assign s1_fire    = s1_valid_ff && !s1_blocked;
   assign req_stall  = s1_valid_ff && s1_blocked;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   // drop the sample into the partial scan; board bit is {row, mux, half}
   always_comb begin
      partial_board_in = partial_board_ff;
      partial_black_in = partial_black_ff;
      partial_white_in = partial_white_ff;
      for (int k = 0; k < smsd_pkg::BOARD_MUXES; k++) begin
         partial_board_in[{s1_channel_ff[2:0], 2'(k), s1_channel_ff[3]}] =
            ~s1_lines_ff[smsd_pkg::BOARD_LINE0 + k];
      end
      partial_black_in[s1_channel_ff] = ~s1_lines_ff[smsd_pkg::BLACK_LINE];
      partial_white_in[s1_channel_ff] = ~s1_lines_ff[smsd_pkg::WHITE_LINE];
   end

   assign scan_match = (partial_board_in == cand_board_ff) &&
                       (partial_black_in == cand_black_ff) &&
                       (partial_white_in == cand_white_ff);
   assign threshold  = (stable_scans_ff == 4'd0) ? 4'd1 : stable_scans_ff;

   always_comb begin
      cand_board_in   = cand_board_ff;
      cand_black_in   = cand_black_ff;
      cand_white_in   = cand_white_ff;
      stable_count_in = stable_count_ff;
      debounce_step   = 1'b0;
      if (s1_last) begin
         if (!scan_match) begin
            cand_board_in   = partial_board_in;
            cand_black_in   = partial_black_in;
            cand_white_in   = partial_white_in;
            stable_count_in = 4'd1;
            debounce_step   = 1'b1;
         end else if (stable_count_ff != smsd_pkg::COUNT_MAX) begin
            stable_count_in = stable_count_ff + 4'd1;
            debounce_step   = 1'b1;
         end
      end
   end

   // new candidate equals the full scan in both branches
   assign at_base = (partial_board_in == base_board_ff) &&
                    (partial_black_in == base_black_ff) &&
                    (partial_white_in == base_white_ff);
   assign settle  = s1_fire && debounce_step && (stable_count_in == threshold) && !at_base;

   smsd_classify u_classify (
      .black_slots (partial_black_in),
      .white_slots (partial_white_in),
      .base_black  (base_black_ff),
      .base_white  (base_white_ff),
      .capture     (capture)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (settle) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_scans_ff  <= smsd_pkg::STABLE_RESET;
         base_board_ff    <= 64'd0;
         base_black_ff    <= 16'd0;
         base_white_ff    <= 16'd0;
         s1_valid_ff      <= 1'b0;
         partial_board_ff <= 64'd0;
         partial_black_ff <= 16'd0;
         partial_white_ff <= 16'd0;
         cand_board_ff    <= 64'd0;
         cand_black_ff    <= 16'd0;
         cand_white_ff    <= 16'd0;
         stable_count_ff  <= 4'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            partial_board_ff <= partial_board_in;
            partial_black_ff <= partial_black_in;
            partial_white_ff <= partial_white_in;
            cand_board_ff    <= cand_board_in;
            cand_black_ff    <= cand_black_in;
            cand_white_ff    <= cand_white_in;
            stable_count_ff  <= stable_count_in;
         end
         if (csr_wen) begin
            unique case (csr_index)
               smsd_pkg::CSR_STABLE_SCANS: stable_scans_ff <= csr_wdata[3:0];
               smsd_pkg::CSR_BASE_BOARD:   base_board_ff   <= csr_wdata;
               smsd_pkg::CSR_BASE_BLACK:   base_black_ff   <= csr_wdata[15:0];
               smsd_pkg::CSR_BASE_WHITE:   base_white_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_channel_ff <= req_channel;
         s1_lines_ff   <= req_sense_lines;
      end
      if (settle) begin
         rsp_board_ff   <= partial_board_in;
         rsp_black_ff   <= partial_black_in;
         rsp_white_ff   <= partial_white_in;
         rsp_capture_ff <= capture;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_board        = rsp_board_ff;
   assign rsp_black_slots  = rsp_black_ff;
   assign rsp_white_slots  = rsp_white_ff;
   assign rsp_capture_kind = rsp_capture_ff.kind;
   assign rsp_capture_slot = rsp_capture_ff.slot;

   `SMSD_ASSERT_NOW(a_stall_only_last, clock, reset, req_stall, s1_valid_ff && s1_last && rsp_valid_ff, "input stalled without a pending last-channel transaction")
   `SMSD_ASSERT_NEXT(a_count_nonzero, clock, reset, s1_fire && s1_last, stable_count_ff != 4'd0, "debounce count zero after a full scan")
   `SMSD_ASSERT_NOW(a_slot_zero, clock, reset, rsp_valid && (rsp_capture_kind == smsd_pkg::KIND_NONE || rsp_capture_kind == smsd_pkg::KIND_MULTI), rsp_capture_slot == 4'd0, "capture slot set without a single capture")
   `SMSD_ASSERT_NOW(a_black_slot_set, clock, reset, rsp_valid && rsp_capture_kind == smsd_pkg::KIND_BLACK, rsp_black_slots[rsp_capture_slot], "black capture slot not occupied")
   `SMSD_ASSERT_NOW(a_white_slot_set, clock, reset, rsp_valid && rsp_capture_kind == smsd_pkg::KIND_WHITE, rsp_white_slots[rsp_capture_slot], "white capture slot not occupied")

endmodule
